// ----- hw/rtl/bhsc_pkg.sv -----
// Shared types, codes and constants for the hall-sensor six-step commutator.
`timescale 1ns / 1ps

package bhsc_pkg;

  // Fixed field widths of the block's ports.
  localparam int DUTY_W       = 16;
  localparam int STEP_W       = 3;
  localparam int HALL_W       = 3;
  localparam int LIMIT_W      = 4;
  localparam int EDGE_W       = 16;
  localparam int TABLE_W      = 36;
  localparam int CFG_IDX_W    = 2;

  // Default compare resolution.
  localparam int DUTY_BITS_DEF = 16;

  // Step table layout: six entries per direction, twelve in all.
  localparam int STEPS_PER_DIR = 6;
  localparam int TABLE_ENTRIES = 12;
  localparam int TABLE_SLOTS   = 16;

  // Reset value of the invalid-code limit.
  localparam logic [LIMIT_W-1:0] HALL_LIMIT_RST = 4'd10;

  // Hall codes that never occur on a healthy sensor.
  localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
  localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;

  // Highest step that drives a phase.
  localparam logic [STEP_W-1:0] STEP_MAX = 3'd5;

  // Low-side switch patterns: bit 0 phase A, bit 1 phase B, bit 2 phase C.
  localparam logic [2:0] LOW_OFF = 3'b000;
  localparam logic [2:0] LOW_A   = 3'b001;
  localparam logic [2:0] LOW_B   = 3'b010;
  localparam logic [2:0] LOW_C   = 3'b100;

  typedef logic [DUTY_W-1:0] duty_t;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_HALL  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_DUTY  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_STEP_TABLE = 2'd1,
    CFG_HALL_LIMIT = 2'd2
  } cfg_idx_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic                 direction;
    logic [TABLE_W-1:0]   step_table;
    logic [LIMIT_W-1:0]   hall_fault_limit;
  } cfg_t;

  // One registered input item.
  typedef struct packed {
    op_t                op;
    logic [HALL_W-1:0]  hall;
    duty_t              duty;
    logic               fault;
    logic               ext_error;
  } item_t;

  // One result item.
  typedef struct packed {
    duty_t              duty_a;
    duty_t              duty_b;
    duty_t              duty_c;
    logic [2:0]         low;
    logic [STEP_W-1:0]  step;
    logic               running;
    logic               error;
    logic [EDGE_W-1:0]  edge_count;
  } result_t;

endpackage

// ----- hw/rtl/bhsc_cfg.sv -----
// Configuration register bank of the hall-sensor six-step commutator.
`timescale 1ns / 1ps

module bhsc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [bhsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhsc_pkg::TABLE_W-1:0]     cfg_wdata,
  output logic                             cfg_ready,
  output bhsc_pkg::cfg_t                   cfg
);

  bhsc_pkg::cfg_t cfg_r;
  bhsc_pkg::cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Decode the register index; indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bhsc_pkg::cfg_idx_t'(cfg_index))
        bhsc_pkg::CFG_DIRECTION: begin
          cfg_nxt.direction = cfg_wdata[0];
        end
        bhsc_pkg::CFG_STEP_TABLE: begin
          cfg_nxt.step_table = cfg_wdata;
        end
        bhsc_pkg::CFG_HALL_LIMIT: begin
          cfg_nxt.hall_fault_limit = cfg_wdata[bhsc_pkg::LIMIT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction        <= 1'b0;
      cfg_r.step_table       <= '0;
      cfg_r.hall_fault_limit <= bhsc_pkg::HALL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/bhsc_core.sv -----
// Commutation state and the single-pass update applied to each registered item.
`timescale 1ns / 1ps

module bhsc_core #(
  parameter int DUTY_BITS = bhsc_pkg::DUTY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bhsc_pkg::item_t     item,
  input  bhsc_pkg::cfg_t      cfg,
  output bhsc_pkg::result_t   res
);

  logic                                run_r, run_nxt;
  logic [bhsc_pkg::STEP_W-1:0]         last_step_r, last_step_nxt;
  logic [bhsc_pkg::LIMIT_W-1:0]        bad_cnt_r, bad_cnt_nxt;
  logic                                err_r, err_nxt;
  logic [bhsc_pkg::EDGE_W-1:0]         edges_r, edges_nxt;
  logic [DUTY_BITS-1:0]                cmp_r   [3];
  logic [DUTY_BITS-1:0]                cmp_nxt [3];
  logic [2:0]                          low_r, low_nxt;

  logic [2:0]                          tbl [bhsc_pkg::TABLE_SLOTS];
  logic [3:0]                          entry;
  logic [bhsc_pkg::STEP_W-1:0]         tbl_step;
  logic                                hall_ok;
  logic                                err_in;
  logic [bhsc_pkg::LIMIT_W:0]          cnt_inc;
  logic                                cnt_sat;
  logic [DUTY_BITS-1:0]                duty_m;

  // Unpack the step table into twelve entries; unused slots read as zero.
  for (genvar g = 0; g < bhsc_pkg::TABLE_SLOTS; g++) begin : g_tbl
    if (g < bhsc_pkg::TABLE_ENTRIES) begin : g_used
      assign tbl[g] = cfg.step_table[3*g +: 3];
    end else begin : g_unused
      assign tbl[g] = '0;
    end
  end

  // Table entry is direction * 6 + hall - 1.
  assign entry    = (cfg.direction ? 4'(bhsc_pkg::STEPS_PER_DIR) : 4'd0)
                  + 4'(item.hall) - 4'd1;
  assign tbl_step = tbl[entry];

  // Hall code check and the saturating invalid-code counter.
  assign hall_ok = (item.hall != bhsc_pkg::HALL_ALL_LOW) &&
                   (item.hall != bhsc_pkg::HALL_ALL_HIGH);
  assign cnt_inc = {1'b0, bad_cnt_r} + 5'd1;
  assign cnt_sat = cnt_inc >= {1'b0, cfg.hall_fault_limit};

  // An external error latches before anything else in the item.
  assign err_in = err_r | item.ext_error;
  assign duty_m = item.duty[DUTY_BITS-1:0];

  // Next state for the item.
  always_comb begin
    logic                        do_comm;
    logic [bhsc_pkg::STEP_W-1:0] comm_step;
    logic                        do_drive;
    logic [bhsc_pkg::STEP_W-1:0] drive_step;

    run_nxt       = run_r;
    last_step_nxt = last_step_r;
    bad_cnt_nxt   = bad_cnt_r;
    err_nxt       = err_in;
    edges_nxt     = edges_r;
    cmp_nxt       = cmp_r;
    low_nxt       = low_r;
    do_comm       = 1'b0;
    comm_step     = tbl_step;
    do_drive      = 1'b0;
    drive_step    = last_step_r;

    unique case (item.op)
      bhsc_pkg::OP_HALL, bhsc_pkg::OP_START: begin
        if (hall_ok) begin
          bad_cnt_nxt = '0;
          if (item.op == bhsc_pkg::OP_HALL) begin
            edges_nxt = edges_r + 1'b1;
            do_comm   = run_r && !err_in;
          end else begin
            run_nxt = 1'b1;
            do_comm = 1'b1;
          end
        end else begin
          bad_cnt_nxt = cnt_sat ? cfg.hall_fault_limit : cnt_inc[bhsc_pkg::LIMIT_W-1:0];
          err_nxt     = err_in | cnt_sat;
        end
      end
      bhsc_pkg::OP_STOP: begin
        run_nxt = 1'b0;
        cmp_nxt = '{default: '0};
        low_nxt = bhsc_pkg::LOW_OFF;
      end
      bhsc_pkg::OP_DUTY: begin
        do_drive = 1'b1;
      end
      default: begin
        run_nxt = run_r;
      end
    endcase

    // Commutation: a fault turns everything off and keeps the last step.
    if (do_comm) begin
      if (item.fault) begin
        cmp_nxt = '{default: '0};
        low_nxt = bhsc_pkg::LOW_OFF;
      end else begin
        last_step_nxt = comm_step;
        if (comm_step > bhsc_pkg::STEP_MAX) begin
          cmp_nxt = '{default: '0};
          low_nxt = bhsc_pkg::LOW_OFF;
        end else begin
          do_drive   = 1'b1;
          drive_step = comm_step;
          unique case (comm_step)
            3'd0, 3'd5: low_nxt = bhsc_pkg::LOW_B;
            3'd1, 3'd2: low_nxt = bhsc_pkg::LOW_C;
            default:    low_nxt = bhsc_pkg::LOW_A;
          endcase
        end
      end
    end

    // High-side compare: one phase gets the duty, steps six and seven do nothing.
    if (do_drive) begin
      unique case (drive_step[2:1])
        2'd0: begin
          cmp_nxt    = '{default: '0};
          cmp_nxt[0] = duty_m;
        end
        2'd1: begin
          cmp_nxt    = '{default: '0};
          cmp_nxt[1] = duty_m;
        end
        2'd2: begin
          cmp_nxt    = '{default: '0};
          cmp_nxt[2] = duty_m;
        end
        default: begin
          cmp_nxt = cmp_nxt;
        end
      endcase
    end
  end

  // State registers advance only when an item completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      last_step_r <= '0;
      bad_cnt_r   <= '0;
      err_r       <= 1'b0;
      edges_r     <= '0;
      cmp_r       <= '{default: '0};
      low_r       <= bhsc_pkg::LOW_OFF;
    end else if (fire) begin
      run_r       <= run_nxt;
      last_step_r <= last_step_nxt;
      bad_cnt_r   <= bad_cnt_nxt;
      err_r       <= err_nxt;
      edges_r     <= edges_nxt;
      cmp_r       <= cmp_nxt;
      low_r       <= low_nxt;
    end
  end

  // The result reports the state after the update.
  always_comb begin
    res.duty_a     = bhsc_pkg::duty_t'(cmp_nxt[0]);
    res.duty_b     = bhsc_pkg::duty_t'(cmp_nxt[1]);
    res.duty_c     = bhsc_pkg::duty_t'(cmp_nxt[2]);
    res.low        = low_nxt;
    res.step       = last_step_nxt;
    res.running    = run_nxt;
    res.error      = err_nxt;
    res.edge_count = edges_nxt;
  end

endmodule

// ----- hw/rtl/bldc_hall_six_step_commutator_unit.sv -----
// Top level of the hall-sensor six-step commutator: input and result registers.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one event per transfer: a
//   hall edge, start, stop or duty update, with the hall code, duty value and
//   fault flags. Every event produces exactly one result on the output
//   channel (out_valid/out_ready): the three high-side compare values, the
//   three low-side switch states, the last step, run and error flags and the
//   count of valid hall edges.
//   The configuration channel (cfg_valid/cfg_ready) writes direction (0),
//   step table (1) or hall fault limit (2); it is always ready and should be
//   used only while no event is in flight.
//   An event passes the input register and then the result register before
//   out_valid rises. One event is taken every cycle while the receiver
//   keeps up: the update is a single table lookup and compare selection
//   between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more event; in_ready drops only when both hold.
//   Reset (synchronous, rst_n low) clears all flags, counters, compares and
//   switches, and loads the hall fault limit with 10.
`timescale 1ns / 1ps

module bldc_hall_six_step_commutator_unit #(
  parameter int DUTY_BITS = bhsc_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bhsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhsc_pkg::TABLE_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [bhsc_pkg::HALL_W-1:0]     in_hall,
  input  logic [bhsc_pkg::DUTY_W-1:0]     in_duty,
  input  logic                            in_fault,
  input  logic                            in_ext_error,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bhsc_pkg::DUTY_W-1:0]     out_duty_a,
  output logic [bhsc_pkg::DUTY_W-1:0]     out_duty_b,
  output logic [bhsc_pkg::DUTY_W-1:0]     out_duty_c,
  output logic                            out_low_a,
  output logic                            out_low_b,
  output logic                            out_low_c,
  output logic [bhsc_pkg::STEP_W-1:0]     out_step,
  output logic                            out_running,
  output logic                            out_error,
  output logic [bhsc_pkg::EDGE_W-1:0]     out_edge_count
);

  bhsc_pkg::cfg_t     cfg;
  bhsc_pkg::item_t    item_r, item_nxt;
  logic               item_vld_r, item_vld_nxt;
  bhsc_pkg::result_t  res;
  bhsc_pkg::result_t  res_r, res_nxt;
  logic               res_vld_r, res_vld_nxt;
  logic               advance;
  logic               fire;
  logic               in_xfer;

  bhsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // Pipeline control: the item moves on when the result register is free.
  assign advance  = !res_vld_r || out_ready;
  assign fire     = item_vld_r && advance;
  assign in_ready = !item_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // Input register.
  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (in_xfer) begin
      item_nxt.op        = bhsc_pkg::op_t'(in_op);
      item_nxt.hall      = in_hall;
      item_nxt.duty      = in_duty;
      item_nxt.fault     = in_fault;
      item_nxt.ext_error = in_ext_error;
      item_vld_nxt       = 1'b1;
    end else if (fire) begin
      item_vld_nxt = 1'b0;
    end
  end

  bhsc_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_comb begin
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    if (fire) begin
      res_nxt     = res;
      res_vld_nxt = 1'b1;
    end else if (out_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // Result channel outputs.
  assign out_valid      = res_vld_r;
  assign out_duty_a     = res_r.duty_a;
  assign out_duty_b     = res_r.duty_b;
  assign out_duty_c     = res_r.duty_c;
  assign out_low_a      = res_r.low[0];
  assign out_low_b      = res_r.low[1];
  assign out_low_c      = res_r.low[2];
  assign out_step       = res_r.step;
  assign out_running    = res_r.running;
  assign out_error      = res_r.error;
  assign out_edge_count = res_r.edge_count;

endmodule

// ----- hw/rtl/bhsc_checker.sv -----
// Port-level assertions for the hall-sensor six-step commutator, bound to the top level.
`timescale 1ns / 1ps

module bhsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bhsc_pkg::DUTY_W-1:0]     out_duty_a,
  input logic [bhsc_pkg::DUTY_W-1:0]     out_duty_b,
  input logic [bhsc_pkg::DUTY_W-1:0]     out_duty_c,
  input logic                            out_low_a,
  input logic                            out_low_b,
  input logic                            out_low_c,
  input logic                            out_running,
  input logic                            out_error
);

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_a) &&
      $stable(out_duty_b) && $stable(out_duty_c) && $stable(out_error))
    else $error("result changed while stalled");

  // The error flag is sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |=> out_error)
    else $error("sticky error flag cleared");

  // At most one low-side switch is on.
  a_low_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_low_a, out_low_b, out_low_c}))
    else $error("more than one low-side switch on");

  // At most one high-side compare is driven.
  a_high_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({|out_duty_a, |out_duty_b, |out_duty_c}) <= 1)
    else $error("more than one high-side phase driven");

  // A stopped motor has every low-side switch off.
  a_stop_low_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> !out_low_a && !out_low_b && !out_low_c)
    else $error("low-side switch on while stopped");

endmodule

bind bldc_hall_six_step_commutator_unit bhsc_checker u_bhsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_duty_a  (out_duty_a),
  .out_duty_b  (out_duty_b),
  .out_duty_c  (out_duty_c),
  .out_low_a   (out_low_a),
  .out_low_b   (out_low_b),
  .out_low_c   (out_low_c),
  .out_running (out_running),
  .out_error   (out_error)
);
